FILE: rtl/core/top_three_bottom_three_index_select_defines.svh
// assertion macros for the top-three / bottom-three index selector
// no dependencies; included by the files that carry assertions
`ifndef TOP_THREE_BOTTOM_THREE_INDEX_SELECT_DEFINES_SVH
`define TOP_THREE_BOTTOM_THREE_INDEX_SELECT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TTBT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ttbt assertion failed");

// next-cycle implication, disabled during reset
`define TTBT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ttbt assertion failed");

`endif

FILE: rtl/core/ttbt_pkg.sv
// shared constants, types and helpers of the top-three / bottom-three selector
// no dependencies; used by the channel interfaces and every module
package ttbt_pkg;

    localparam int MAX_ITEMS = 256;
    localparam int KEEP      = 3;
    localparam int WEAR_W    = 14;
    localparam int OUT_IDX_W = 8;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int POS_W     = $clog2(KEEP + 1);

    typedef logic [WEAR_W-1:0]    wear_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [POS_W-1:0]     pos_t;
    typedef logic [OUT_IDX_W-1:0] out_idx_t;

    // per-cycle control of one ranked list
    typedef struct packed {
        logic step;   // insert the current word
        pos_t fill;   // entries valid before the insert
    } list_ctl_t;

    // number of valid list entries for a given item count
    function automatic pos_t fill_of(cnt_t count);
        pos_t f;
        if (count >= CNT_W'(KEEP))
            f = POS_W'(KEEP);
        else
            f = POS_W'(count);
        return f;
    endfunction

endpackage

FILE: rtl/core/ttbt_channels.sv
// valid/ready channel interfaces for input words and result words
// depends on ttbt_pkg
interface ttbt_item_if;
    import ttbt_pkg::*;

    logic  valid;
    logic  ready;
    wear_t wear;
    logic  last_item;

    modport source (output valid, output wear, output last_item, input ready);
    modport sink   (input valid, input wear, input last_item, output ready);
endinterface

interface ttbt_result_if;
    import ttbt_pkg::*;

    logic     valid;
    logic     ready;
    out_idx_t high_first;
    out_idx_t high_second;
    out_idx_t high_third;
    out_idx_t low_first;
    out_idx_t low_second;
    out_idx_t low_third;
    logic     too_few;
    logic     overflowed;

    modport source (
        output valid, output high_first, output high_second, output high_third,
        output low_first, output low_second, output low_third,
        output too_few, output overflowed, input ready
    );
    modport sink (
        input valid, input high_first, input high_second, input high_third,
        input low_first, input low_second, input low_third,
        input too_few, input overflowed, output ready
    );
endinterface

FILE: rtl/core/ttbt_rank_list.sv
// three-entry ranked list with compare-and-insert, highest or lowest kept
// depends on ttbt_pkg
module ttbt_rank_list (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  keep_high,
    input  ttbt_pkg::list_ctl_t   ctl,
    input  ttbt_pkg::wear_t       wear,
    input  ttbt_pkg::idx_t        idx,
    output ttbt_pkg::idx_t        idx_next [ttbt_pkg::KEEP]
);
    import ttbt_pkg::*;

    wear_t val_reg  [KEEP];
    idx_t  idx_reg  [KEEP];
    wear_t val_next [KEEP];
    logic  hit      [KEEP];
    pos_t  pos;

    // first entry the new word outranks; fill when it outranks none
    always_comb
    begin
        for (int k = 0; k < KEEP; k++)
        begin
            hit[k] = (POS_W'(k) < ctl.fill) &&
                     (keep_high ? (wear >= val_reg[k]) : (wear < val_reg[k]));
        end
        pos = ctl.fill;
        for (int k = KEEP - 1; k >= 0; k--)
        begin
            if (hit[k])
                pos = POS_W'(k);
        end
    end

    // shift entries below the insert point down by one
    always_comb
    begin
        for (int j = 0; j < KEEP; j++)
        begin
            if (!ctl.step || POS_W'(j) < pos)
            begin
                val_next[j] = val_reg[j];
                idx_next[j] = idx_reg[j];
            end
            else if (POS_W'(j) == pos)
            begin
                val_next[j] = wear;
                idx_next[j] = idx;
            end
            else if (j > 0)
            begin
                val_next[j] = val_reg[j-1];
                idx_next[j] = idx_reg[j-1];
            end
            else
            begin
                val_next[j] = val_reg[j];
                idx_next[j] = idx_reg[j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < KEEP; j++)
            begin
                val_reg[j] <= '0;
                idx_reg[j] <= '0;
            end
        end
        else
        begin
            for (int j = 0; j < KEEP; j++)
            begin
                val_reg[j] <= val_next[j];
                idx_reg[j] <= idx_next[j];
            end
        end
    end

endmodule

FILE: rtl/core/ttbt_sort3.sv
// ascending sort of the valid list indices, unused fields forced to zero
// depends on ttbt_pkg
module ttbt_sort3 (
    input  ttbt_pkg::idx_t     idx  [ttbt_pkg::KEEP],
    input  ttbt_pkg::pos_t     fill,
    output ttbt_pkg::out_idx_t sorted [ttbt_pkg::KEEP]
);
    import ttbt_pkg::*;

    typedef logic [IDX_W:0] key_t;

    key_t k0, k1, k2;
    key_t a0, a1, b1, b2, c0, c1;
    key_t res [KEEP];

    // invalid entries get the top key bit so they sort to the end
    always_comb
    begin
        k0 = {!(POS_W'(0) < fill), idx[0]};
        k1 = {!(POS_W'(1) < fill), idx[1]};
        k2 = {!(POS_W'(2) < fill), idx[2]};
        // three compare-swap steps
        a0 = (k0 > k1) ? k1 : k0;
        a1 = (k0 > k1) ? k0 : k1;
        b1 = (a1 > k2) ? k2 : a1;
        b2 = (a1 > k2) ? a1 : k2;
        c0 = (a0 > b1) ? b1 : a0;
        c1 = (a0 > b1) ? a0 : b1;
        res[0] = c0;
        res[1] = c1;
        res[2] = b2;
        for (int j = 0; j < KEEP; j++)
        begin
            if (res[j][IDX_W])
                sorted[j] = '0;
            else
                sorted[j] = OUT_IDX_W'(res[j][IDX_W-1:0]);
        end
    end

endmodule

FILE: rtl/core/top_three_bottom_three_index_select.sv
// top level of the streaming top-three / bottom-three index selector
// depends on ttbt_pkg, ttbt_channels, ttbt_rank_list, ttbt_sort3 and the defines header
//
//  channel  | dir | word contents                                  | when
//  ---------+-----+------------------------------------------------+---------------------
//  item     | in  | wear, last_item                                | one per disk
//  result   | out | high/low first..third, too_few, overflowed     | one per run, on last
//
// one word per cycle sustained outside stalls: a word sits in the input register, where
// the two three-entry lists compare and insert it; on the last word the sorted
// indices land in the result register the next edge
// the only back-pressure is a last word waiting while the result register is full
// and not taken; ordinary words keep flowing while a result waits
// reset clears counts and lists; no clearing pass is needed
`include "top_three_bottom_three_index_select_defines.svh"

module top_three_bottom_three_index_select (
    input logic          clk,
    input logic          rst_n,
    ttbt_item_if.sink    item,
    ttbt_result_if.source result
);
    import ttbt_pkg::*;

    // input register
    logic  s1_valid_reg, s1_valid_next;
    wear_t s1_wear_reg;
    logic  s1_last_reg;

    // run state
    cnt_t  item_count_reg, item_count_next;
    logic  overflow_seen_reg, overflow_seen_next;

    // result register
    logic     out_valid_reg, out_valid_next;
    out_idx_t high_reg [KEEP];
    out_idx_t low_reg  [KEEP];
    logic     too_few_reg;
    logic     overflowed_reg;

    logic      go;
    logic      in_cap;
    logic      finish;
    cnt_t      count_after;
    list_ctl_t list_ctl;
    pos_t      fill_after;
    idx_t      top_idx_next [KEEP];
    idx_t      bot_idx_next [KEEP];
    out_idx_t  high_sorted  [KEEP];
    out_idx_t  low_sorted   [KEEP];

    // the input register drains unless a last word finds the result slot busy
    assign go     = s1_valid_reg && (!s1_last_reg || !out_valid_reg || result.ready);
    assign finish = go && s1_last_reg;
    assign item.ready = !s1_valid_reg || go;

    // words past capacity are dropped but still close the run
    assign in_cap      = item_count_reg < CNT_W'(MAX_ITEMS);
    assign count_after = in_cap ? item_count_reg + CNT_W'(1) : item_count_reg;
    assign fill_after  = fill_of(count_after);

    assign list_ctl.step = go && in_cap;
    assign list_ctl.fill = fill_of(item_count_reg);

    ttbt_rank_list u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .keep_high (1'b1),
        .ctl       (list_ctl),
        .wear      (s1_wear_reg),
        .idx       (item_count_reg[IDX_W-1:0]),
        .idx_next  (top_idx_next)
    );

    ttbt_rank_list u_bottom (
        .clk       (clk),
        .rst_n     (rst_n),
        .keep_high (1'b0),
        .ctl       (list_ctl),
        .wear      (s1_wear_reg),
        .idx       (item_count_reg[IDX_W-1:0]),
        .idx_next  (bot_idx_next)
    );

    ttbt_sort3 u_sort_high (
        .idx    (top_idx_next),
        .fill   (fill_after),
        .sorted (high_sorted)
    );

    ttbt_sort3 u_sort_low (
        .idx    (bot_idx_next),
        .fill   (fill_after),
        .sorted (low_sorted)
    );

    always_comb
    begin
        s1_valid_next = item.ready ? item.valid : s1_valid_reg;

        item_count_next    = item_count_reg;
        overflow_seen_next = overflow_seen_reg;
        if (finish)
        begin
            // run closes: start over from an empty list
            item_count_next    = '0;
            overflow_seen_next = 1'b0;
        end
        else if (go)
        begin
            item_count_next    = count_after;
            overflow_seen_next = overflow_seen_reg || !in_cap;
        end

        if (finish)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            item_count_reg    <= '0;
            overflow_seen_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg      <= s1_valid_next;
            item_count_reg    <= item_count_next;
            overflow_seen_reg <= overflow_seen_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
        begin
            s1_wear_reg <= item.wear;
            s1_last_reg <= item.last_item;
        end
        if (finish)
        begin
            for (int j = 0; j < KEEP; j++)
            begin
                high_reg[j] <= high_sorted[j];
                low_reg[j]  <= low_sorted[j];
            end
            too_few_reg    <= count_after < CNT_W'(KEEP);
            overflowed_reg <= overflow_seen_reg || !in_cap;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.high_first  = high_reg[0];
    assign result.high_second = high_reg[1];
    assign result.high_third  = high_reg[2];
    assign result.low_first   = low_reg[0];
    assign result.low_second  = low_reg[1];
    assign result.low_third   = low_reg[2];
    assign result.too_few     = too_few_reg;
    assign result.overflowed  = overflowed_reg;

    // a closed run always leaves a result and an empty count behind
    `TTBT_ASSERT_NXT(a_finish_result, clk, rst_n, finish, out_valid_reg && item_count_reg == '0)
    // overflow can only be recorded once the count is full
    `TTBT_ASSERT_IMP(a_overflow_full, clk, rst_n, overflow_seen_reg, !in_cap)
    // input stalls only behind a last word blocked by a waiting result
    `TTBT_ASSERT_IMP(a_stall_cause, clk, rst_n, !item.ready,
        s1_valid_reg && s1_last_reg && out_valid_reg && !result.ready)
    // an ordinary word within capacity bumps the count by one
    `TTBT_ASSERT_NXT(a_count_step, clk, rst_n, go && !s1_last_reg && in_cap,
        item_count_reg == $past(item_count_reg) + CNT_W'(1))

endmodule

FILE: verif/testbench.sv
// self-checking testbench for the top-three / bottom-three index selector
// depends on ttbt_pkg, the ttbt channel interfaces and the selector rtl
import ttbt_pkg::*;

// one result word as the testbench sees it
typedef struct {
    out_idx_t high_idx[KEEP];
    out_idx_t low_idx[KEEP];
    bit       too_few;
    bit       overflowed;
} run_summary_t;

// how the wear values of one random run are drawn
typedef enum int {
    SPREAD_FULL,
    TIES_TIGHT,
    EXTREMES,
    RISING,
    FALLING
} wear_style_t;

// tracks the ranked lists of the current run and the summaries still owed
class wear_ranker;
    wear_t        top_wear[KEEP];
    int           top_pos[KEEP];
    wear_t        bot_wear[KEEP];
    int           bot_pos[KEEP];
    int           count;
    bit           overflow_seen;
    run_summary_t owed[$];
    int           mismatches;
    int           summaries_seen;
    int           runs_closed;
    int           short_runs;
    int           overflow_runs;

    function void clear_run();
        for (int k = 0; k < KEEP; k++)
        begin
            top_wear[k] = '0;
            top_pos[k]  = 0;
            bot_wear[k] = '0;
            bot_pos[k]  = 0;
        end
        count         = 0;
        overflow_seen = 0;
    endfunction

    // shift the tail down and drop the word in at pos
    function void insert_at(bit to_top, int n, int pos, wear_t w, int ix);
        int k;
        if (pos >= KEEP)
            return;
        k = (n < KEEP) ? n : KEEP - 1;
        while (k > pos)
        begin
            if (to_top)
            begin
                top_wear[k] = top_wear[k-1];
                top_pos[k]  = top_pos[k-1];
            end
            else
            begin
                bot_wear[k] = bot_wear[k-1];
                bot_pos[k]  = bot_pos[k-1];
            end
            k--;
        end
        if (to_top)
        begin
            top_wear[pos] = w;
            top_pos[pos]  = ix;
        end
        else
        begin
            bot_wear[pos] = w;
            bot_pos[pos]  = ix;
        end
    endfunction

    // first n indices in ascending order, the rest zero
    function void sort_out(input int idxs[KEEP], input int n, output out_idx_t dst[KEEP]);
        int q[$];
        for (int i = 0; i < n; i++)
            q = {q, idxs[i]};
        q.sort();
        for (int i = 0; i < KEEP; i++)
            dst[i] = (i < q.size()) ? out_idx_t'(q[i]) : '0;
    endfunction

    // note one accepted input word
    function void take_word(wear_t w, bit last);
        int           n;
        int           pos;
        run_summary_t s;
        n = (count < KEEP) ? count : KEEP;
        if (count < MAX_ITEMS)
        begin
            // newest word wins ties on the top list
            pos = n;
            for (int k = 0; k < n; k++)
                if (w >= top_wear[k])
                begin
                    pos = k;
                    break;
                end
            insert_at(1'b1, n, pos, w, count);
            // older word stays lower on ties on the bottom list
            pos = n;
            for (int k = 0; k < n; k++)
                if (w < bot_wear[k])
                begin
                    pos = k;
                    break;
                end
            insert_at(1'b0, n, pos, w, count);
            count++;
        end
        else
            overflow_seen = 1;
        if (!last)
            return;
        n = (count < KEEP) ? count : KEEP;
        sort_out(top_pos, n, s.high_idx);
        sort_out(bot_pos, n, s.low_idx);
        s.too_few    = (count < KEEP);
        s.overflowed = overflow_seen;
        runs_closed++;
        if (s.too_few)
            short_runs++;
        if (s.overflowed)
            overflow_runs++;
        owed = {owed, s};
        clear_run();
    endfunction

    task report(string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    // compare one result word with the oldest owed summary
    task check_summary(run_summary_t got);
        run_summary_t want;
        if (owed.size() == 0)
        begin
            report("result word with no run outstanding");
            return;
        end
        want = owed.pop_front();
        summaries_seen++;
        for (int k = 0; k < KEEP; k++)
        begin
            if (got.high_idx[k] !== want.high_idx[k])
                report($sformatf("run %0d high index %0d: got %0d want %0d",
                                 summaries_seen, k, got.high_idx[k], want.high_idx[k]));
            if (got.low_idx[k] !== want.low_idx[k])
                report($sformatf("run %0d low index %0d: got %0d want %0d",
                                 summaries_seen, k, got.low_idx[k], want.low_idx[k]));
        end
        if (got.too_few !== want.too_few)
            report($sformatf("run %0d too_few: got %0b want %0b",
                             summaries_seen, got.too_few, want.too_few));
        if (got.overflowed !== want.overflowed)
            report($sformatf("run %0d overflowed: got %0b want %0b",
                             summaries_seen, got.overflowed, want.overflowed));
    endtask
endclass

module testbench;
    // generous bound on total cycles
    localparam int CYCLE_LIMIT  = 250000;
    localparam int RANDOM_WORDS = 1400;

    logic clk;
    logic rst_n;

    ttbt_item_if   item_ch();
    ttbt_result_if result_ch();

    top_three_bottom_three_index_select dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    wear_ranker   board;
    run_summary_t seen_summary;
    wear_t        run_vals[$];
    bit           steady;       // no gaps on either side while set
    int           stall_left;
    int           words_sent;
    int           cycles;

    always #2 clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 55)
            return 0;
        else if (r < 85)
            return int'($urandom_range(1, 2));
        else if (r < 97)
            return int'($urandom_range(3, 6));
        return int'($urandom_range(10, 25));
    endfunction

    // offer one word after an optional gap, hold it until taken
    task automatic send_word(input wear_t w, input bit last);
        int gap;
        gap = steady ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.wear      <= w;
        item_ch.last_item <= last;
        do @(posedge clk); while (!item_ch.ready);
        board.take_word(w, last);
        words_sent++;
    endtask

    // send the words in run_vals as one run
    task automatic send_listed();
        for (int i = 0; i < run_vals.size(); i++)
            send_word(run_vals[i], i == run_vals.size() - 1);
    endtask

    task automatic send_random_run(input int len, input wear_style_t style);
        wear_t base;
        wear_t w;
        int    step;
        base = wear_t'($urandom_range(0, 16383));
        step = int'($urandom_range(0, 64));
        for (int i = 0; i < len; i++)
        begin
            case (style)
                SPREAD_FULL: w = wear_t'($urandom_range(0, 16383));
                TIES_TIGHT:  w = wear_t'($urandom_range(0, 3));
                EXTREMES:
                begin
                    case ($urandom_range(0, 3))
                        0:       w = '0;
                        1:       w = '1;
                        2:       w = 14'd10000;
                        default: w = wear_t'($urandom_range(0, 16383));
                    endcase
                end
                RISING:      w = base + wear_t'(i * step);
                default:     w = base - wear_t'(i * step);
            endcase
            send_word(w, i == len - 1);
        end
    endtask

    // drop valid and hold off until every owed summary has come back
    task automatic drain();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (board.owed.size() != 0)
            @(posedge clk);
    endtask

    // result side: ready with random stalls, steady stretches keep it high
    always @(negedge clk)
    begin
        if (stall_left > 0 && !steady)
        begin
            result_ch.ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            result_ch.ready <= 1'b1;
            stall_left = 0;
            if (!steady && $urandom_range(0, 99) < 25)
                stall_left = pick_gap();
        end
    end

    // check every result word taken at a rising edge
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            seen_summary.high_idx[0] = result_ch.high_first;
            seen_summary.high_idx[1] = result_ch.high_second;
            seen_summary.high_idx[2] = result_ch.high_third;
            seen_summary.low_idx[0]  = result_ch.low_first;
            seen_summary.low_idx[1]  = result_ch.low_second;
            seen_summary.low_idx[2]  = result_ch.low_third;
            seen_summary.too_few     = result_ch.too_few;
            seen_summary.overflowed  = result_ch.overflowed;
            board.check_summary(seen_summary);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial
    begin
        int start_words;
        int run_no;
        int len;
        int r;

        board = new;
        board.clear_run();
        clk                 = 1'b0;
        rst_n               = 1'b0;
        item_ch.valid       = 1'b0;
        item_ch.wear        = '0;
        item_ch.last_item   = 1'b0;
        result_ch.ready     = 1'b0;
        steady              = 1'b0;
        stall_left          = 0;
        words_sent          = 0;
        cycles              = 0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: single word run at the top wear value
        run_vals = '{14'h3FFF};
        send_listed();
        // two word run, still short
        run_vals = '{14'h0000, 14'h3FFF};
        send_listed();
        // all equal, ranking falls to index alone
        run_vals = '{14'd5, 14'd5, 14'd5};
        send_listed();
        // equal pairs at both extremes and in the middle
        run_vals = '{14'h0000, 14'h3FFF, 14'h0000, 14'h3FFF, 14'd7, 14'd7};
        send_listed();
        // alternating bit patterns, every wear bit toggles
        run_vals = '{14'h2AAA, 14'h1555, 14'h3FFF, 14'h0000, 14'h2AAA};
        send_listed();
        // strictly falling run
        run_vals = '{14'd9, 14'd8, 14'd7, 14'd6};
        send_listed();

        // hold the sender until the directed summaries are all back
        drain();

        // random runs: mostly short, three long ones around capacity
        start_words = words_sent;
        run_no      = 0;
        while (words_sent - start_words < RANDOM_WORDS)
        begin
            r = int'($urandom_range(0, 99));
            if (run_no == 4)
                len = MAX_ITEMS;             // exactly full, no overflow
            else if (run_no == 15)
                len = MAX_ITEMS + 1;         // last word itself past capacity
            else if (run_no == 30)
                len = MAX_ITEMS + 40;        // long tail of ignored words
            else if (r < 15)
                len = int'($urandom_range(1, 2));
            else if (r < 90)
                len = int'($urandom_range(3, 12));
            else
                len = int'($urandom_range(13, 40));
            steady = ($urandom_range(0, 99) < 15);
            send_random_run(len, wear_style_t'($urandom_range(0, 4)));
            if ($urandom_range(0, 99) < 5)
                drain();
            run_no++;
        end
        steady = 1'b0;

        // let the pipeline empty, then keep the clock running to catch stray words
        drain();
        repeat (8) @(posedge clk);

        $display("sent %0d words in %0d runs, %0d short and %0d past capacity",
                 words_sent, board.runs_closed, board.short_runs, board.overflow_runs);
        $display("checked %0d summaries, %0d mismatches",
                 board.summaries_seen, board.mismatches);
        if (board.mismatches == 0 && board.owed.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule
